>>> design/cma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered moving average: shared package
// Default sizes and the fixed width of the radius write data.
// ----------------------------------------------------------------------------
package cma_pkg;

    // Largest supported radius; the window holds 2*MAX_RADIUS+1 samples.
    localparam int MAX_RADIUS  = 63;
    // Width of one input sample.
    localparam int SAMPLE_BITS = 16;
    // Width of the radius write data on the configuration port.
    localparam int RADIUS_BITS = 6;

endpackage

>>> design/cma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 127
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/cma_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered moving average: reciprocal unit
// Compute floor(2^SUM_BITS / window) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cma_recip #(
    parameter int MAX_RADIUS  = cma_pkg::MAX_RADIUS,
    parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  logic                                                     start,
    input  logic [$clog2(2*MAX_RADIUS+2)-1:0]                        divisor,
    output logic                                                     busy,
    output logic [SAMPLE_BITS+$clog2(2*MAX_RADIUS+2):0]              recip
);

    localparam int WIN_BITS = $clog2(2 * MAX_RADIUS + 2);
    localparam int SUM_BITS = SAMPLE_BITS + WIN_BITS;
    localparam int Q_BITS   = SUM_BITS + 1;
    localparam int CNT_BITS = $clog2(Q_BITS + 1);

    logic                busy_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [WIN_BITS:0]   rem_reg;
    logic [WIN_BITS-1:0] div_reg;
    logic [Q_BITS-1:0]   quo_reg;

    logic                bit_in;
    logic [WIN_BITS:0]   trial;
    logic                ge;
    logic [WIN_BITS:0]   rem_next;

    // Dividend is a one followed by SUM_BITS zeros.
    assign bit_in   = (cnt_reg == CNT_BITS'(Q_BITS));
    assign trial    = {rem_reg[WIN_BITS-1:0], bit_in};
    assign ge       = (trial >= {1'b0, div_reg});
    assign rem_next = ge ? (trial - {1'b0, div_reg}) : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= WIN_BITS'(1);
            // Window of one after reset: reciprocal is exactly 2^SUM_BITS.
            quo_reg  <= Q_BITS'(1) << SUM_BITS;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(Q_BITS);
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[Q_BITS-2:0], ge};
            cnt_reg  <= cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy  = busy_reg;
    assign recip = quo_reg;

endmodule

>>> design/centered_moving_average_core.sv
// The first result is offered after the read/sum, multiply and fix states of an accepted request.
// The sequencer finishes a request, with any end-of-stream results and stalled results, before
//   it takes the next one.
// A radius write holds off requests while the reciprocal unit iterates. Reset clears radius,
//   sum, count and ring position; the delay-line RAM is not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered moving average filter core
// Delay line in RAM, running sum, division by the window through a
// reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module centered_moving_average_core #(
    parameter int MAX_RADIUS  = cma_pkg::MAX_RADIUS,
    parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cma_pkg::RADIUS_BITS-1:0] radius,
    // Sample channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SAMPLE_BITS-1:0]        sample,
    input  logic                          end_of_stream,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS:0]   average,
    output logic                          last_of_run
);

    localparam int DEPTH     = 2 * MAX_RADIUS + 1;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
    localparam int WIN_BITS  = RAD_W + 1;
    localparam int SUM_BITS  = SAMPLE_BITS + WIN_BITS;
    localparam int Q_BITS    = SUM_BITS + 1;
    localparam int PROD_BITS = SUM_BITS + Q_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // Control state
    logic [2:0]             state_reg, state_next;
    logic [RAD_W-1:0]       radius_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [WIN_BITS-1:0]    seen_reg;
    logic [ADDR_BITS-1:0]   wp_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [RAD_W-1:0]       extra_reg, extra_next;

    // Per-request context
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic                   eos_reg;
    logic                   full_reg;
    logic                   has_avg_reg;
    logic [SUM_BITS-1:0]    div_sum_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic [SAMPLE_BITS:0]   avg_reg, avg_next;
    logic                   last_reg, last_next;

    // Datapath
    logic                   in_fire;
    logic                   cfg_fire;
    logic [WIN_BITS-1:0]    win;
    logic [SAMPLE_BITS-1:0] old_smp;
    logic [SAMPLE_BITS-1:0] rdata;
    logic                   full_old;
    logic [SUM_BITS-1:0]    sum_upd;
    logic [WIN_BITS-1:0]    seen_upd;
    logic [ADDR_BITS-1:0]   wp_upd;
    logic [RAD_W-1:0]       extra_upd;
    logic [RAD_W-1:0]       radius_sat;
    logic                   recip_busy;
    logic [Q_BITS-1:0]      recip;
    logic [SAMPLE_BITS-1:0] q0;
    logic [SUM_BITS-1:0]    qd;
    logic [SUM_BITS-1:0]    rem;
    logic [SAMPLE_BITS-1:0] quot;

    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    // Take a radius write only between requests.
    assign cfg_ready = (state_reg == S_IDLE);
    // Take a request only when idle, the reciprocal is settled and no radius
    // write is waiting.
    assign in_ready  = (state_reg == S_IDLE) && !recip_busy && !cfg_valid;

    assign win = {radius_reg, 1'b1};

    // Clamp the written radius to the supported range.
    assign radius_sat = (radius > cma_pkg::RADIUS_BITS'(MAX_RADIUS))
                      ? RAD_W'(MAX_RADIUS)
                      : radius[RAD_W-1:0];

    cma_recip #(
        .MAX_RADIUS  (MAX_RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_fire),
        .divisor ({radius_sat, 1'b1}),
        .busy    (recip_busy),
        .recip   (recip)
    );

    // Read the oldest entry at accept, write the new sample back in the next cycle
    // at the same address. Requests never overlap, so no forwarding is needed.
    cma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (state_reg == S_READ),
        .waddr (wp_reg),
        .wdata (smp_reg),
        .re    (in_fire),
        .raddr (wp_reg),
        .rdata (rdata)
    );

    // Sum update: drop the oldest sample once the window is full, add the new one.
    assign full_old  = (seen_reg == win);
    assign old_smp   = full_old ? rdata : '0;
    assign sum_upd   = sum_reg - SUM_BITS'(old_smp) + SUM_BITS'(smp_reg);
    assign seen_upd  = full_old ? seen_reg : seen_reg + WIN_BITS'(1);
    assign wp_upd    = (wp_reg == ADDR_BITS'({radius_reg, 1'b0}))
                     ? '0 : wp_reg + ADDR_BITS'(1);
    // Trailing positions to flush on end of stream: min(count, radius).
    assign extra_upd = (seen_upd < {1'b0, radius_reg})
                     ? seen_upd[RAD_W-1:0] : radius_reg;

    // Quotient estimate is the true quotient or one below; fix with one compare.
    assign q0   = prod_reg[SUM_BITS +: SAMPLE_BITS];
    assign qd   = SUM_BITS'(q0) * SUM_BITS'(win);
    assign rem  = div_sum_reg - qd;
    assign quot = (rem >= SUM_BITS'(win)) ? q0 + SAMPLE_BITS'(1) : q0;

    // Sequencer and result register
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        extra_next     = extra_reg;
        avg_next       = avg_reg;
        last_next      = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_MUL;
                extra_next = eos_reg ? extra_upd : '0;
            end
            S_MUL:
            begin
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (has_avg_reg)
                begin
                    avg_next       = full_reg ? {1'b0, quot} : '1;
                    last_next      = (extra_reg == '0);
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else if (extra_reg != '0)
                begin
                    avg_next       = '1;
                    last_next      = (extra_reg == RAD_W'(1));
                    extra_next     = extra_reg - RAD_W'(1);
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (extra_reg != '0)
                    begin
                        // Flush one more trailing position as -1.
                        avg_next   = '1;
                        last_next  = (extra_reg == RAD_W'(1));
                        extra_next = extra_reg - RAD_W'(1);
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= '0;
            sum_reg       <= '0;
            seen_reg      <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
            extra_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            extra_reg     <= extra_next;
            if (cfg_fire)
            begin
                // A new radius starts a new stream.
                radius_reg <= radius_sat;
                sum_reg    <= '0;
                seen_reg   <= '0;
                wp_reg     <= '0;
            end
            else if (state_reg == S_READ)
            begin
                if (eos_reg)
                begin
                    sum_reg  <= '0;
                    seen_reg <= '0;
                    wp_reg   <= '0;
                end
                else
                begin
                    sum_reg  <= sum_upd;
                    seen_reg <= seen_upd;
                    wp_reg   <= wp_upd;
                end
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            smp_reg <= sample;
            eos_reg <= end_of_stream;
        end
        if (state_reg == S_READ)
        begin
            div_sum_reg <= sum_upd;
            full_reg    <= (seen_upd == win);
            has_avg_reg <= (seen_upd > {1'b0, radius_reg});
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_BITS'(div_sum_reg) * PROD_BITS'(recip);
        end
        avg_reg  <= avg_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign average     = avg_reg;
    assign last_of_run = last_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // A result is only offered from the output state.
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_OUT))
        else $error("result offered outside output state");

    // Sample count never passes the window length.
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= win)
        else $error("sample count above window length");

    // Ring position stays inside the window.
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wp_reg} < {1'b0, win})
        else $error("ring position outside window");

    // An accepted request starts the read-modify-write of the delay line.
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_READ))
        else $error("accepted request did not start a line access");

endmodule

>>> tb/sv/cma_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered moving average: result checker
// Watches the radius, sample and result channels, predicts the window means
// of every accepted request and compares each accepted result in order.
// ----------------------------------------------------------------------------
module cma_result_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [cma_pkg::RADIUS_BITS-1:0]        radius,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic [cma_pkg::SAMPLE_BITS-1:0]        sample,
    input  logic                                   end_of_stream,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [cma_pkg::SAMPLE_BITS:0]   average,
    input  logic                                   last_of_run,
    output int                                     failures,
    output int                                     outstanding
);

    localparam int LINE_DEPTH = 2 * cma_pkg::MAX_RADIUS + 1;
    localparam int AVG_BITS   = cma_pkg::SAMPLE_BITS + 1;
    localparam int SUM_BITS   = cma_pkg::SAMPLE_BITS + 7;
    localparam logic signed [AVG_BITS-1:0] NOT_FIT = '1;

    typedef struct packed {
        logic signed [AVG_BITS-1:0] average;
        logic                       last_of_run;
    } window_result_t;

    logic [cma_pkg::SAMPLE_BITS-1:0] ring [LINE_DEPTH];
    logic [SUM_BITS-1:0]             win_sum;
    int                              samples_seen;
    int                              write_pos;
    int                              cur_radius;
    int                              printed;
    window_result_t                  expected_means[$];

    task automatic report_mismatch(string msg);
        failures = failures + 1;
        if (printed < 40)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        printed = printed + 1;
    endtask

    function automatic void clear_stream();
        win_sum      = '0;
        samples_seen = 0;
        write_pos    = 0;
    endfunction

    // Advance the window by one sample and queue the results it causes.
    function automatic void predict_window_means(logic [cma_pkg::SAMPLE_BITS-1:0] smp,
                                                 logic eos);
        window_result_t             r;
        int                         win;
        int                         pos;
        int                         extra;
        int                         n;
        logic                       has_mean;
        logic signed [AVG_BITS-1:0] mean;
        win = 2 * cur_radius + 1;
        pos = (write_pos < win) ? write_pos : 0;
        if (samples_seen >= win)
            win_sum -= ring[pos];
        ring[pos] = smp;
        win_sum += smp;
        write_pos = (pos + 1 >= win) ? 0 : pos + 1;
        if (samples_seen < win)
            samples_seen++;
        has_mean = (samples_seen >= cur_radius + 1);
        mean = (samples_seen >= win) ? AVG_BITS'(win_sum / win) : NOT_FIT;
        extra = 0;
        if (eos)
        begin
            // Flush the trailing positions, which never get a full window.
            extra = (samples_seen < cur_radius) ? samples_seen : cur_radius;
            clear_stream();
        end
        n = (has_mean ? 1 : 0) + extra;
        for (int i = 0; i < n; i++)
        begin
            r.average      = (has_mean && i == 0) ? mean : NOT_FIT;
            r.last_of_run  = (i == n - 1);
            expected_means = {expected_means, r};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t e;
        if (!rst_n)
        begin
            clear_stream();
            cur_radius = 0;
            expected_means.delete();
            failures = 0;
            printed = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cur_radius = (int'(radius) > cma_pkg::MAX_RADIUS)
                           ? cma_pkg::MAX_RADIUS : int'(radius);
                clear_stream();
            end
            if (in_valid && in_ready)
                predict_window_means(sample, end_of_stream);
            if (out_valid && out_ready)
            begin
                if (expected_means.size() == 0)
                    report_mismatch($sformatf("unexpected result average=%0d last=%0b",
                                              average, last_of_run));
                else
                begin
                    e = expected_means.pop_front();
                    if (average !== e.average)
                        report_mismatch($sformatf("average got %0d expected %0d",
                                                  average, e.average));
                    if (last_of_run !== e.last_of_run)
                        report_mismatch($sformatf("last_of_run got %0b expected %0b",
                                                  last_of_run, e.last_of_run));
                end
            end
            outstanding <= expected_means.size();
        end
    end

endmodule

>>> tb/sv/centered_moving_average_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered moving average: testbench top
// Drives radius writes and sample streams with random idle bursts on both
// sides; the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module centered_moving_average_core_test;

    localparam int LIMIT_CYCLES = 2000000;
    // Covers the result latency of a request that causes no result.
    localparam int SETTLE_CYCLES = 24;
    // Samples from the long stream on through the random phases.
    localparam int RANDOM_ITEMS = 180;
    localparam logic [cma_pkg::SAMPLE_BITS-1:0] FULL_SCALE = '1;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [cma_pkg::RADIUS_BITS-1:0]       radius;
    logic                                  in_valid;
    logic                                  in_ready;
    logic [cma_pkg::SAMPLE_BITS-1:0]       sample;
    logic                                  end_of_stream;
    logic                                  out_valid;
    logic                                  out_ready = 1'b0;
    logic signed [cma_pkg::SAMPLE_BITS:0]  average;
    logic                                  last_of_run;
    int                                    failures;
    int                                    outstanding;

    int  cycles = 0;
    int  stall_left = 0;
    bit  stall_mode = 1'b1;
    bit  calm = 1'b0;
    int  random_sent = 0;

    centered_moving_average_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .radius        (radius),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .average       (average),
        .last_of_run   (last_of_run)
    );

    cma_result_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .radius        (radius),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .average       (average),
        .last_of_run   (last_of_run),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stop a hung run; any timeout counts as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side backpressure: drop ready in bursts,
    // with whole stretches of no stalls, and none once the run turns calm.
    always @(posedge clk)
    begin
        if (cycles % 128 == 0)
            stall_mode <= ($urandom_range(0, 2) != 0);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!calm && stall_mode && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 15);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Hold a sample request until the core accepts it. An idle burst may
    // come first; valid is lowered only when one does.
    task automatic push_sample(logic [cma_pkg::SAMPLE_BITS-1:0] smp, logic eos);
        if (!calm && stall_mode && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        sample        <= smp;
        end_of_stream <= eos;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop the sample valid and wait until every predicted result is back,
    // then give a request that causes no result time to leave the pipeline.
    task automatic await_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the radius only with the core idle; every write restarts the stream.
    task automatic write_radius(int r);
        await_drain();
        cfg_valid <= 1'b1;
        radius    <= cma_pkg::RADIUS_BITS'(r);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Favor the extremes so that full-scale sums show up often.
    function automatic logic [cma_pkg::SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return FULL_SCALE;
            default: return cma_pkg::SAMPLE_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int pick_radius();
        case ($urandom_range(0, 9)) inside
            [0:1]:   return 0;
            2:       return cma_pkg::MAX_RADIUS;
            3:       return $urandom_range(0, cma_pkg::MAX_RADIUS);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // Send one stream of random samples; close it with end of stream or
    // leave it open so the next radius write cuts it off.
    task automatic run_stream(int len, bit closed);
        for (int i = 0; i < len; i++)
        begin
            push_sample(random_sample(), closed && (i == len - 1));
            random_sent++;
            if (random_sent >= RANDOM_ITEMS - 40)
                calm = 1'b1;
        end
    endtask

    initial
    begin
        int r;
        int win;
        int nstreams;
        int len;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        radius        <= '0;
        in_valid      <= 1'b0;
        sample        <= '0;
        end_of_stream <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Radius zero out of reset: each sample passes through unchanged.
        push_sample('0, 1'b0);
        push_sample(FULL_SCALE, 1'b0);
        push_sample(16'h5555, 1'b1);
        push_sample(16'hAAAA, 1'b1);

        // Radius one: extremes through a sliding window, then a one-sample
        // stream that is shorter than the window.
        write_radius(1);
        push_sample('0, 1'b0);
        push_sample(FULL_SCALE, 1'b0);
        push_sample(FULL_SCALE, 1'b0);
        push_sample(16'd1, 1'b0);
        push_sample(16'd2, 1'b1);
        push_sample(16'd7, 1'b1);

        // Leave a radius-two stream open; the next write must clear it.
        write_radius(2);
        push_sample(16'd100, 1'b0);
        push_sample(FULL_SCALE, 1'b0);
        push_sample(16'd3, 1'b0);

        // Largest radius with short streams: every position is -1.
        write_radius(cma_pkg::MAX_RADIUS);
        push_sample(16'd10, 1'b0);
        push_sample(16'd20, 1'b1);
        push_sample(FULL_SCALE, 1'b1);

        // Full window of full-scale samples: largest sum for its radius.
        write_radius(3);
        for (int i = 0; i < 7; i++)
            push_sample(FULL_SCALE, i == 6);

        // One long stream at the largest radius so the window fills and slides.
        write_radius(cma_pkg::MAX_RADIUS);
        run_stream(2 * cma_pkg::MAX_RADIUS + 1 + $urandom_range(1, 6), 1'b1);

        // Random phases: mostly small radii and streams around the window
        // length, some left open across the next radius write.
        while (random_sent < RANDOM_ITEMS)
        begin
            r = pick_radius();
            write_radius(r);
            win = 2 * r + 1;
            nstreams = $urandom_range(1, 4);
            for (int s = 0; s < nstreams; s++)
            begin
                if (random_sent >= RANDOM_ITEMS)
                    break;
                len = $urandom_range(1, 2 * win + 3);
                if (len > 40)
                    len = $urandom_range(1, 40);
                run_stream(len, (s < nstreams - 1) || ($urandom_range(0, 3) != 0));
            end
        end

        await_drain();
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
